FILE: hw/rtl/mks_pkg.sv
// ----------------------------------------------------------------------------
// mks_pkg: shared types and constants for the matrix keypad scanner
// Column count, register map and the column-to-index helper.
// ----------------------------------------------------------------------------
package mks_pkg;

	// keypad geometry (fixed)
	localparam int unsigned COLUMNS     = 4;
	localparam int unsigned ROW_DRIVE_W = 6;
	localparam int unsigned WINDOW_W    = 16;
	localparam int unsigned CODE_W      = 5;

	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd10000;
	localparam logic [COLUMNS-1:0]  COLUMN_MASK  = 4'h0F;

	// register map: index taken from the word address
	typedef enum logic [0:0] {
		REG_WINDOW = 1'b0
	} reg_idx_t;

	typedef logic [COLUMNS-1:0] column_t;

	// index of the highest set column bit, 0 when none is set
	function automatic logic [1:0] column_index(input column_t col);
		logic [1:0] idx;
		idx = 2'd0;
		for (int i = 1; i < COLUMNS; i++) begin
			if (col[i]) begin
				idx = 2'(i);
			end
		end
		return idx;
	endfunction

endpackage

FILE: hw/rtl/matrix_keypad_scanner.sv
// ----------------------------------------------------------------------------
// matrix_keypad_scanner: row scanner for a main and an extended keypad
// Results are registered: each sample transfer loads the result register.
// Throughput: one column sample per cycle while the result register is free
//   or taken; the result register frees itself in the same cycle its result is taken.
// Reset: arst_n clears scan state to row 0 of the main bank and the
//   window register to 10000 samples.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner
	import mks_pkg::*;
#(
	parameter int unsigned MAIN_ROWS = 4,
	parameter int unsigned EXT_ROWS  = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration port
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	// sample channel
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [COLUMNS-1:0]     column_sample,
	// result channel
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [ROW_DRIVE_W-1:0] row_drive,
	output logic                   key_valid,
	output logic [CODE_W-1:0]      key_code,
	output logic                   key_bank
);

	localparam logic [2:0] MAIN_ROWS_N = 3'(MAIN_ROWS);
	localparam logic [2:0] EXT_ROWS_N  = 3'(EXT_ROWS);

	// scan state
	logic                window_q;
	logic [WINDOW_W-1:0] window_samples_q;
	logic                release_wait_q;
	logic                active_bank_q;
	logic [1:0]          active_row_q;
	logic [WINDOW_W-1:0] samples_taken_q;
	column_t             held_column_q;

	// result register
	logic                   out_valid_q;
	logic [ROW_DRIVE_W-1:0] row_drive_q;
	logic                   key_valid_q;
	logic [CODE_W-1:0]      key_code_q;
	logic                   key_bank_q;

	// next-state and result values
	logic                   accept;
	column_t                sample;
	logic [7:0]             drive_full;
	logic                   single_col;
	column_t                held_upd;
	logic [WINDOW_W-1:0]    taken_inc;
	logic [WINDOW_W-1:0]    limit;
	logic [2:0]             bank_rows;
	logic                   release_wait_d;
	logic                   active_bank_d;
	logic [1:0]             active_row_d;
	logic [WINDOW_W-1:0]    samples_taken_d;
	column_t                held_column_d;
	logic                   valid_d;
	logic [CODE_W-1:0]      code_d;
	logic                   bank_d;

	// configuration port
	assign pready   = 1'b1;
	assign window_q = (paddr[2] == REG_WINDOW);
	assign prdata   = window_q ? {16'd0, window_samples_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_samples_q <= WINDOW_RESET;
		end else if (psel && penable && pwrite && pready && window_q) begin
			window_samples_q <= pwdata[WINDOW_W-1:0];
		end
	end

	// handshake: a new sample is taken whenever the result register is free
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// scan step for one sample
	always_comb begin
		sample     = column_sample & COLUMN_MASK;
		drive_full = 8'd1 << {active_bank_q, active_row_q};
		single_col = (sample != '0) && ((sample & (sample - 1'b1)) == '0);
		held_upd   = single_col ? sample : held_column_q;
		taken_inc  = samples_taken_q + 1'b1;
		limit      = (window_samples_q == '0) ? 16'd1 : window_samples_q;
		bank_rows  = active_bank_q ? EXT_ROWS_N : MAIN_ROWS_N;

		release_wait_d  = release_wait_q;
		active_bank_d   = active_bank_q;
		active_row_d    = active_row_q;
		samples_taken_d = samples_taken_q;
		held_column_d   = held_column_q;
		valid_d         = 1'b0;
		code_d          = '0;
		bank_d          = 1'b0;

		if (release_wait_q) begin
			// wait for all columns low, then report and switch bank
			if (sample == '0) begin
				valid_d         = 1'b1;
				code_d          = 5'({active_row_q, 2'b00}) + 5'(COLUMNS)
				                  - 5'(column_index(held_column_q));
				bank_d          = active_bank_q;
				active_bank_d   = !active_bank_q;
				active_row_d    = '0;
				samples_taken_d = '0;
				held_column_d   = '0;
				release_wait_d  = 1'b0;
			end
		end else begin
			held_column_d   = held_upd;
			samples_taken_d = taken_inc;
			if (taken_inc >= limit) begin
				if (held_upd != '0) begin
					release_wait_d = 1'b1;
				end else begin
					samples_taken_d = '0;
					held_column_d   = '0;
					if ({1'b0, active_row_q} + 3'd1 >= bank_rows) begin
						active_bank_d = !active_bank_q;
						active_row_d  = '0;
					end else begin
						active_row_d = active_row_q + 2'd1;
					end
				end
			end
		end
	end

	// state update on each sample transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			release_wait_q  <= 1'b0;
			active_bank_q   <= 1'b0;
			active_row_q    <= '0;
			samples_taken_q <= '0;
			held_column_q   <= '0;
		end else if (accept) begin
			release_wait_q  <= release_wait_d;
			active_bank_q   <= active_bank_d;
			active_row_q    <= active_row_d;
			samples_taken_q <= samples_taken_d;
			held_column_q   <= held_column_d;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			row_drive_q <= drive_full[ROW_DRIVE_W-1:0];
			key_valid_q <= valid_d;
			key_code_q  <= code_d;
			key_bank_q  <= bank_d;
		end
	end

	assign out_valid = out_valid_q;
	assign row_drive = row_drive_q;
	assign key_valid = key_valid_q;
	assign key_code  = key_code_q;
	assign key_bank  = key_bank_q;

endmodule
